>>> src/gbts_pkg.sv
package gbts_pkg;

    // default store size in characters
    localparam int DEF_CAPACITY = 1024;

    // request and result field widths
    localparam int KIND_W   = 3;
    localparam int CH_W     = 8;
    localparam int CNT_W    = 11;
    localparam int POS_W    = 11;
    localparam int DELTA_W  = 12;
    localparam int STATUS_W = 2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic move_en;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic go_move;
        logic move_busy;
    } t_dp_sts;

endpackage

>>> src/gbts_ctrl.sv
module gbts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output gbts_pkg::t_dp_cmd o_cmd,
    input  gbts_pkg::t_dp_sts i_sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOVE = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       out_free;
    logic       load_out;
    logic       accept;

    // result register can take a new result
    assign out_free = !r_out_valid || !i_out_stall;
    assign load_out = (r_state == S_FIN) && out_free;

    // a new request enters when idle or while the last result is handed off
    assign o_in_stall = !((r_state == S_IDLE) || load_out);
    assign accept     = i_in_valid && !o_in_stall;

    assign o_cmd.accept   = accept;
    assign o_cmd.move_en  = (r_state == S_MOVE);
    assign o_cmd.load_out = load_out;
    assign o_out_valid    = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE, S_FIN: begin
                if (accept) begin
                    n_state = i_sts.go_move ? S_MOVE : S_FIN;
                end else if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            S_MOVE: begin
                if (!i_sts.move_busy) begin
                    n_state = S_FIN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> src/gbts_dp.sv
module gbts_dp #(
    parameter int CAPACITY = gbts_pkg::DEF_CAPACITY
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gbts_pkg::t_dp_cmd                    i_cmd,
    output gbts_pkg::t_dp_sts                    o_sts,
    input  logic [gbts_pkg::KIND_W-1:0]          i_kind,
    input  logic [gbts_pkg::CH_W-1:0]            i_ch,
    input  logic [gbts_pkg::CNT_W-1:0]           i_erase_count,
    input  logic [gbts_pkg::POS_W-1:0]           i_position,
    input  logic signed [gbts_pkg::DELTA_W-1:0]  i_delta,
    output logic [gbts_pkg::STATUS_W-1:0]        o_status,
    output logic [gbts_pkg::CH_W-1:0]            o_read_char,
    output logic [gbts_pkg::POS_W-1:0]           o_cursor_pos,
    output logic [gbts_pkg::POS_W-1:0]           o_text_length,
    output logic                                 o_is_empty
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = ((PW > gbts_pkg::DELTA_W) ? PW : gbts_pkg::DELTA_W) + 1;

    // character store
    logic [gbts_pkg::CH_W-1:0] r_mem [CAPACITY];
    logic [gbts_pkg::CH_W-1:0] r_rdata;

    // gap pointers, length, move target
    logic [PW-1:0] r_gs;
    logic [PW-1:0] r_ge;
    logic [PW-1:0] r_len;
    logic [PW-1:0] r_tgt;
    logic [AW-1:0] r_waddr;
    logic          r_pend;
    logic [gbts_pkg::STATUS_W-1:0] r_status;
    logic          r_rd_ok;

    logic [EW-1:0]        len_e;
    logic [EW-1:0]        gs_e;
    logic [EW-1:0]        pos_e;
    logic [EW-1:0]        cnt_e;
    logic signed [EW-1:0] mv_sum;
    logic [EW-1:0]        rd_sum;
    logic [PW-1:0]        mv_tgt;
    logic [PW-1:0]        erased;
    logic                 full;
    logic                 rd_ok;
    logic                 set_ok;
    logic                 step_l;
    logic                 step_r;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [gbts_pkg::CH_W-1:0] wdata;
    logic                 re;
    logic [AW-1:0]        raddr;

    // request decode against current text
    assign len_e  = EW'(r_len);
    assign gs_e   = EW'(r_gs);
    assign pos_e  = EW'(i_position);
    assign cnt_e  = EW'(i_erase_count);
    assign full   = (r_gs == r_ge);
    assign rd_ok  = (pos_e < len_e);
    assign set_ok = !(pos_e > len_e);
    assign erased = (cnt_e > gs_e) ? r_gs : PW'(i_erase_count);
    assign rd_sum = (pos_e < gs_e) ? pos_e : (pos_e + EW'(r_ge) - gs_e);

    // relative move target clamped to the text
    assign mv_sum = signed'(gs_e) + EW'(i_delta);
    always_comb begin
        if (mv_sum < 0) begin
            mv_tgt = '0;
        end else if (mv_sum > signed'(len_e)) begin
            mv_tgt = r_len;
        end else begin
            mv_tgt = PW'(mv_sum);
        end
    end

    // one gap step per cycle while moving
    assign step_l = i_cmd.move_en && (r_gs > r_tgt);
    assign step_r = i_cmd.move_en && (r_gs < r_tgt) && (r_ge < PW'(CAPACITY));

    assign o_sts.go_move   = ((i_kind == gbts_pkg::KIND_SET) && set_ok)
                             || (i_kind == gbts_pkg::KIND_MOVE);
    assign o_sts.move_busy = step_l || step_r || r_pend;

    // store port select
    always_comb begin
        we    = 1'b0;
        waddr = r_waddr;
        wdata = r_rdata;
        re    = 1'b0;
        raddr = AW'(r_ge);
        if (i_cmd.accept && (i_kind == gbts_pkg::KIND_INSERT) && !full) begin
            we    = 1'b1;
            waddr = AW'(r_gs);
            wdata = i_ch;
        end else if (i_cmd.move_en && r_pend) begin
            we = 1'b1;
        end
        if (i_cmd.accept && (i_kind == gbts_pkg::KIND_READ) && rd_ok) begin
            re    = 1'b1;
            raddr = AW'(rd_sum);
        end else if (step_l) begin
            re    = 1'b1;
            raddr = AW'(r_gs - PW'(1));
        end else if (step_r) begin
            re    = 1'b1;
            raddr = AW'(r_ge);
        end
    end

    // store access
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // gap pointers and pending copy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs   <= '0;
            r_ge   <= PW'(CAPACITY);
            r_len  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= step_l || step_r;
            if (i_cmd.accept) begin
                unique case (i_kind)
                    gbts_pkg::KIND_INSERT: begin
                        if (!full) begin
                            r_gs  <= r_gs + PW'(1);
                            r_len <= r_len + PW'(1);
                        end
                    end
                    gbts_pkg::KIND_ERASE: begin
                        r_gs  <= r_gs - erased;
                        r_len <= r_len - erased;
                    end
                    default: ;
                endcase
            end else if (step_l) begin
                r_gs <= r_gs - PW'(1);
                r_ge <= r_ge - PW'(1);
            end else if (step_r) begin
                r_gs <= r_gs + PW'(1);
                r_ge <= r_ge + PW'(1);
            end
        end
    end

    // request bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_ok <= (i_kind == gbts_pkg::KIND_READ) && rd_ok;
            unique case (i_kind)
                gbts_pkg::KIND_INSERT: begin
                    r_status <= full ? gbts_pkg::STATUS_FULL : gbts_pkg::STATUS_OK;
                end
                gbts_pkg::KIND_SET: begin
                    if (set_ok) begin
                        r_tgt    <= PW'(i_position);
                        r_status <= gbts_pkg::STATUS_OK;
                    end else begin
                        r_status <= gbts_pkg::STATUS_RANGE;
                    end
                end
                gbts_pkg::KIND_MOVE: begin
                    r_tgt    <= mv_tgt;
                    r_status <= gbts_pkg::STATUS_OK;
                end
                gbts_pkg::KIND_READ: begin
                    r_status <= rd_ok ? gbts_pkg::STATUS_OK : gbts_pkg::STATUS_RANGE;
                end
                default: begin
                    r_status <= gbts_pkg::STATUS_OK;
                end
            endcase
        end
        if (step_l) begin
            r_waddr <= AW'(r_ge - PW'(1));
        end else if (step_r) begin
            r_waddr <= AW'(r_gs);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status      <= r_status;
            o_read_char   <= r_rd_ok ? r_rdata : '0;
            o_cursor_pos  <= gbts_pkg::POS_W'(r_gs);
            o_text_length <= gbts_pkg::POS_W'(r_len);
            o_is_empty    <= (r_len == '0);
        end
    end

endmodule

>>> src/gap_buffer_text_store.sv
// Gap buffer text store: a CAPACITY-character store with a cursor at the gap
// start. Each request inserts, erases before the cursor, sets or moves the
// cursor, or reads one character, and returns one result with status, read
// character, cursor and text length. Insert, erase, read and rejected
// requests are taken one per cycle back to back: the store access happens at
// the edge that takes the request and the result register loads as soon as it
// is free, together with the next request. Set and move requests stall the
// input while the characters between the old and new cursor are copied
// across the gap at one per cycle through the single store write port.
// A stalled result holds off the next request. The store is not cleared
// after reset and needs no start-up time.
module gap_buffer_text_store #(
    parameter int CAPACITY = gbts_pkg::DEF_CAPACITY
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [gbts_pkg::KIND_W-1:0]          i_kind,
    input  logic [gbts_pkg::CH_W-1:0]            i_ch,
    input  logic [gbts_pkg::CNT_W-1:0]           i_erase_count,
    input  logic [gbts_pkg::POS_W-1:0]           i_position,
    input  logic signed [gbts_pkg::DELTA_W-1:0]  i_delta,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [gbts_pkg::STATUS_W-1:0]        o_status,
    output logic [gbts_pkg::CH_W-1:0]            o_read_char,
    output logic [gbts_pkg::POS_W-1:0]           o_cursor_pos,
    output logic [gbts_pkg::POS_W-1:0]           o_text_length,
    output logic                                 o_is_empty
);

    gbts_pkg::t_dp_cmd cmd;
    gbts_pkg::t_dp_sts sts;

    // request sequencing
    gbts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // store, gap pointers and result register
    gbts_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_kind),
        .i_ch          (i_ch),
        .i_erase_count (i_erase_count),
        .i_position    (i_position),
        .i_delta       (i_delta),
        .o_status      (o_status),
        .o_read_char   (o_read_char),
        .o_cursor_pos  (o_cursor_pos),
        .o_text_length (o_text_length),
        .o_is_empty    (o_is_empty)
    );

endmodule
